// ----- src/rmf_pkg.sv -----
package rmf_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_HALF   = 7;

	// ring of rows in the line store
	localparam int LS_ROWS  = 2 * MAX_HALF + 2;
	localparam int SLOT_W   = $clog2(LS_ROWS);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
	localparam int LS_AW    = $clog2(LS_DEPTH);

	localparam int HALF_W   = $clog2(MAX_HALF + 1);
	localparam int SIDE_W   = HALF_W + 1;
	localparam int SIDE_MAX = 2 * MAX_HALF + 1;
	localparam int N_W      = $clog2(SIDE_MAX * SIDE_MAX + 1);

	localparam int CH_W   = 8;
	localparam int NCH    = 3;
	localparam int PIX_W  = NCH * CH_W;
	localparam int BINS   = 1 << CH_W;
	localparam int CNT_W  = N_W;

	// configuration
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WREG_W     = 12;
	localparam int HREG_W     = 13;
	localparam int HALFREG_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 2'd2;

	localparam logic [WREG_W-1:0]    WIDTH_RST  = 12'd640;
	localparam logic [HREG_W-1:0]    HEIGHT_RST = 13'd480;
	localparam logic [HALFREG_W-1:0] HALF_RST   = 3'd1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GATHER,
		S_FLUSH,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             inc_v;
		pixel_t           pix;
		logic             scan_go;
		logic [CNT_W-1:0] k;
	} hist_cmd_t;

	typedef struct packed {
		logic   ready;
		logic   done;
		pixel_t med;
	} hist_sts_t;

endpackage

// ----- src/rmf_if.sv -----
interface rmf_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
	modport sink (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface rmf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_last;
	modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface rmf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rmf_pkg::CFG_IDX_W-1:0]  addr;
	logic [rmf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ----- src/rmf_ram.sv -----
module rmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read of the entry being written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/rmf_hist.sv -----
module rmf_hist (
	input  logic               clk,
	input  logic               arst_n,
	input  rmf_pkg::hist_cmd_t cmd,
	output rmf_pkg::hist_sts_t sts
);

	localparam int BW = rmf_pkg::CH_W;
	localparam int CW = rmf_pkg::CNT_W;
	localparam int NC = rmf_pkg::NCH;

	logic [BW:0]              clr_q;
	logic                     sc_act_q;
	logic [BW-1:0]            idx_q;
	logic                     rd_v_q;
	logic [BW-1:0]            rd_a_q;
	logic                     done_q;
	logic                     v_s2_q;
	logic [NC-1:0][BW-1:0]    a_s2_q;
	logic                     wv_q;
	logic [NC-1:0][BW-1:0]    wa_q;
	logic [NC-1:0][CW-1:0]    wd_q;
	logic [NC-1:0][CW-1:0]    acc_q;
	logic [NC-1:0]            found_q;
	logic [NC-1:0][BW-1:0]    med_q;

	logic [NC-1:0][BW-1:0]    pick;
	logic [NC-1:0][BW-1:0]    raddr;
	logic [NC-1:0][BW-1:0]    waddr;
	logic [NC-1:0][CW-1:0]    wdata;
	logic [NC-1:0][CW-1:0]    rdata;
	logic [NC-1:0][CW-1:0]    inc;
	logic [NC-1:0][CW-1:0]    acc_n;
	logic                     we;

	always_comb begin
		we = 1'b0;
		for (int ch = 0; ch < NC; ch++) begin
			pick[ch]  = cmd.pix[ch*BW +: BW];
			raddr[ch] = sc_act_q ? idx_q : pick[ch];
			// previous beat wrote the same bin: its count is not in the RAM output yet
			inc[ch]   = ((wv_q && wa_q[ch] == a_s2_q[ch]) ? wd_q[ch] : rdata[ch]) + CW'(1);
			acc_n[ch] = acc_q[ch] + rdata[ch];
			waddr[ch] = a_s2_q[ch];
			wdata[ch] = inc[ch];
			if (!clr_q[BW]) begin
				waddr[ch] = clr_q[BW-1:0];
				wdata[ch] = '0;
			end else if (rd_v_q) begin
				waddr[ch] = rd_a_q;
				wdata[ch] = '0;
			end
		end
		we = !clr_q[BW] || rd_v_q || v_s2_q;
	end

	for (genvar g = 0; g < NC; g++) begin : g_bank
		rmf_ram #(.WIDTH(CW), .DEPTH(rmf_pkg::BINS)) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr[g]),
			.wdata (wdata[g]),
			.raddr (raddr[g]),
			.rdata (rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			sc_act_q <= 1'b0;
			idx_q    <= '0;
			rd_v_q   <= 1'b0;
			done_q   <= 1'b0;
			v_s2_q   <= 1'b0;
			wv_q     <= 1'b0;
			found_q  <= '0;
		end else begin
			if (!clr_q[BW]) begin
				clr_q <= clr_q + (BW+1)'(1);
			end
			v_s2_q <= cmd.inc_v;
			wv_q   <= v_s2_q;
			rd_v_q <= sc_act_q;
			done_q <= rd_v_q && rd_a_q == BW'(rmf_pkg::BINS - 1);
			if (cmd.scan_go) begin
				sc_act_q <= 1'b1;
				idx_q    <= '0;
				found_q  <= '0;
			end else if (sc_act_q) begin
				idx_q <= idx_q + BW'(1);
				if (idx_q == BW'(rmf_pkg::BINS - 1)) begin
					sc_act_q <= 1'b0;
				end
			end
			if (rd_v_q) begin
				for (int ch = 0; ch < NC; ch++) begin
					if (!found_q[ch] && acc_n[ch] > cmd.k) begin
						found_q[ch] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s2_q <= pick;
		rd_a_q <= idx_q;
		wa_q   <= a_s2_q;
		wd_q   <= inc;
		for (int ch = 0; ch < NC; ch++) begin
			if (cmd.scan_go) begin
				acc_q[ch] <= '0;
			end else if (rd_v_q) begin
				acc_q[ch] <= acc_n[ch];
				if (!found_q[ch] && acc_n[ch] > cmd.k) begin
					med_q[ch] <= rd_a_q;
				end
			end
		end
	end

	assign sts.ready = clr_q[BW] && !sc_act_q && !rd_v_q && !v_s2_q;
	assign sts.done  = done_q;
	assign sts.med   = med_q;

endmodule

// ----- src/rgb_median_filter_unit.sv -----
// Sequence: an item that makes no result is only taken; one that makes a result is followed
//   by a walk over the (2*half_window+1)^2 window positions with line store reads, a drain
//   of the histogram update pipe and the histogram scan.
// Throughput: one item at a time; the histogram scan over 256 bins per result sets the rate.
// Reset (arst_n, async low): counters and ring bases to zero, registers to 640x480, half 1;
//   the histogram banks are then zeroed bin by bin while no pixel is taken.
module rgb_median_filter_unit (
	input  logic          clk,
	input  logic          arst_n,
	rmf_cfg_if.sink       cfg,
	rmf_in_if.sink        pix_in,
	rmf_out_if.source     pix_out
);

	localparam int CW = rmf_pkg::COL_W;
	localparam int RW = rmf_pkg::ROW_W;
	localparam int SW = rmf_pkg::SLOT_W;
	localparam int HW = rmf_pkg::HALF_W;
	localparam int DW = rmf_pkg::SIDE_W;

	// configuration registers
	logic [rmf_pkg::WREG_W-1:0]    width_q;
	logic [rmf_pkg::HREG_W-1:0]    height_q;
	logic [rmf_pkg::HALFREG_W-1:0] half_q;

	// framing state
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [SW-1:0] in_base_q, out_base_q;
	logic          in_ahead_q;

	rmf_pkg::state_t state_q, state_n;
	logic [DW-1:0]   gi_q, gj_q;       // window row / column being fetched
	logic [rmf_pkg::N_W-1:0] n_q;      // in-image neighbors counted so far
	logic            ls_rv_q;          // line store read data valid

	// output register
	logic       out_v_q;
	logic [7:0] out_red_q, out_green_q, out_blue_q;
	logic       out_last_q;

	// effective (clamped) geometry
	logic [CW:0]   eff_w;
	logic [RW:0]   eff_h;
	logic [HW-1:0] eff_half;
	logic [DW-1:0] side_m1;

	always_comb begin
		if (width_q == '0) eff_w = (CW+1)'(1);
		else if (width_q > rmf_pkg::WREG_W'(rmf_pkg::MAX_WIDTH)) eff_w = (CW+1)'(rmf_pkg::MAX_WIDTH);
		else eff_w = (CW+1)'(width_q);
		if (height_q == '0) eff_h = (RW+1)'(1);
		else if (height_q > rmf_pkg::HREG_W'(rmf_pkg::MAX_HEIGHT)) eff_h = (RW+1)'(rmf_pkg::MAX_HEIGHT);
		else eff_h = (RW+1)'(height_q);
		if (half_q > rmf_pkg::HALFREG_W'(rmf_pkg::MAX_HALF)) eff_half = HW'(rmf_pkg::MAX_HALF);
		else eff_half = HW'(half_q);
		side_m1 = {eff_half, 1'b0};
	end

	// beat handshakes
	logic in_acc, cfg_acc, is_pix;
	logic out_free;
	rmf_pkg::hist_cmd_t hcmd;
	rmf_pkg::hist_sts_t hsts;

	assign out_free      = !out_v_q || pix_out.ready;
	assign pix_in.ready  = state_q == rmf_pkg::S_IDLE && hsts.ready;
	assign cfg.ready     = state_q == rmf_pkg::S_IDLE;
	assign in_acc        = pix_in.valid && pix_in.ready;
	assign cfg_acc       = cfg.valid && cfg.ready;
	assign is_pix        = pix_in.cmd == rmf_pkg::CMD_PIXEL;

	// input-side counter advance and readiness of the next output
	logic [CW:0]   col_inc, lc_raw, lc, oc_inc;
	logic [RW:0]   row_inc, lr_raw, lr, or_inc;
	logic          col_wrap, row_wrap, frame_wrap;
	logic [CW-1:0] in_col_n;
	logic [RW-1:0] in_row_n;
	logic          ahead_n, out_rdy;

	always_comb begin
		col_inc    = {1'b0, in_col_q} + (CW+1)'(1);
		row_inc    = {1'b0, in_row_q} + (RW+1)'(1);
		col_wrap   = col_inc >= eff_w;
		row_wrap   = row_inc >= eff_h;
		frame_wrap = is_pix && col_wrap && row_wrap;
		in_col_n   = in_col_q;
		in_row_n   = in_row_q;
		if (is_pix) begin
			in_col_n = col_wrap ? '0 : col_inc[CW-1:0];
			if (col_wrap) in_row_n = row_wrap ? '0 : row_inc[RW-1:0];
		end
		ahead_n = in_ahead_q || frame_wrap;
		// last pixel this output needs, clipped to the image
		lr_raw  = {1'b0, out_row_q} + (RW+1)'(eff_half);
		lc_raw  = {1'b0, out_col_q} + (CW+1)'(eff_half);
		lr      = (lr_raw > eff_h - (RW+1)'(1)) ? eff_h - (RW+1)'(1) : lr_raw;
		lc      = (lc_raw > eff_w - (CW+1)'(1)) ? eff_w - (CW+1)'(1) : lc_raw;
		out_rdy = ahead_n || ({1'b0, in_row_n} > lr)
			|| ({1'b0, in_row_n} == lr && {1'b0, in_col_n} > lc);
		oc_inc  = {1'b0, out_col_q} + (CW+1)'(1);
		or_inc  = {1'b0, out_row_q} + (RW+1)'(1);
	end

	// window position: offset coordinates so no signed math is needed
	logic [RW:0]   rr, r;
	logic [CW:0]   cc, c;
	logic          pos_ok;
	logic [SW-1:0] rd_slot, wr_slot;

	always_comb begin
		rr      = {1'b0, out_row_q} + (RW+1)'(gi_q);
		cc      = {1'b0, out_col_q} + (CW+1)'(gj_q);
		r       = rr - (RW+1)'(eff_half);
		c       = cc - (CW+1)'(eff_half);
		pos_ok  = rr >= (RW+1)'(eff_half) && r < eff_h
			&& cc >= (CW+1)'(eff_half) && c < eff_w;
		rd_slot = out_base_q + r[SW-1:0];
		wr_slot = in_base_q + in_row_q[SW-1:0];
	end

	logic                          ls_re;
	logic [rmf_pkg::PIX_W-1:0] ls_rdata;

	rmf_ram #(.WIDTH(rmf_pkg::PIX_W), .DEPTH(rmf_pkg::LS_DEPTH)) u_line_store (
		.clk   (clk),
		.we    (in_acc && is_pix),
		.waddr ({wr_slot, in_col_q}),
		.wdata ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
		.raddr ({rd_slot, c[CW-1:0]}),
		.rdata (ls_rdata)
	);

	assign hcmd.inc_v   = ls_rv_q;
	assign hcmd.pix     = ls_rdata;
	assign hcmd.scan_go = state_q == rmf_pkg::S_FLUSH && !ls_rv_q && hsts.ready;
	assign hcmd.k       = n_q >> 1;

	rmf_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hcmd),
		.sts    (hsts)
	);

	logic gather_end, load_out;

	// sequencer: next state and strobes
	always_comb begin
		state_n    = state_q;
		ls_re      = 1'b0;
		gather_end = gj_q == side_m1 && gi_q == side_m1;
		load_out   = 1'b0;
		case (state_q)
			rmf_pkg::S_IDLE: begin
				if (in_acc && out_rdy && !cfg_acc) state_n = rmf_pkg::S_GATHER;
			end
			rmf_pkg::S_GATHER: begin
				ls_re = pos_ok;
				if (gather_end) state_n = rmf_pkg::S_FLUSH;
			end
			rmf_pkg::S_FLUSH: begin
				if (hcmd.scan_go) state_n = rmf_pkg::S_SCAN;
			end
			rmf_pkg::S_SCAN: begin
				if (hsts.done) state_n = rmf_pkg::S_DONE;
			end
			rmf_pkg::S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_n  = rmf_pkg::S_IDLE;
				end
			end
			default: state_n = rmf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rmf_pkg::S_IDLE;
			width_q    <= rmf_pkg::WIDTH_RST;
			height_q   <= rmf_pkg::HEIGHT_RST;
			half_q     <= rmf_pkg::HALF_RST;
			in_row_q   <= '0;
			in_col_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			in_base_q  <= '0;
			out_base_q <= '0;
			in_ahead_q <= 1'b0;
			gi_q       <= '0;
			gj_q       <= '0;
			n_q        <= '0;
			ls_rv_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			ls_rv_q <= ls_re;
			if (load_out) out_v_q <= 1'b1;
			else if (pix_out.ready) out_v_q <= 1'b0;
			if (cfg_acc) begin
				// any known register write restarts framing
				case (cfg.addr)
					rmf_pkg::CFG_WIDTH:  width_q  <= cfg.data[rmf_pkg::WREG_W-1:0];
					rmf_pkg::CFG_HEIGHT: height_q <= cfg.data[rmf_pkg::HREG_W-1:0];
					rmf_pkg::CFG_HALF:   half_q   <= cfg.data[rmf_pkg::HALFREG_W-1:0];
					default: ;
				endcase
				if (cfg.addr == rmf_pkg::CFG_WIDTH || cfg.addr == rmf_pkg::CFG_HEIGHT
					|| cfg.addr == rmf_pkg::CFG_HALF) begin
					in_row_q   <= '0;
					in_col_q   <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					in_base_q  <= '0;
					out_base_q <= '0;
					in_ahead_q <= 1'b0;
				end
			end else if (in_acc) begin
				in_col_q   <= in_col_n;
				in_row_q   <= in_row_n;
				in_ahead_q <= ahead_n;
				if (frame_wrap) in_base_q <= in_base_q + eff_h[SW-1:0];
				gi_q <= '0;
				gj_q <= '0;
				n_q  <= '0;
			end
			if (state_q == rmf_pkg::S_GATHER) begin
				if (pos_ok) n_q <= n_q + rmf_pkg::N_W'(1);
				if (gj_q == side_m1) begin
					gj_q <= '0;
					gi_q <= gi_q + DW'(1);
				end else begin
					gj_q <= gj_q + DW'(1);
				end
			end
			if (load_out) begin
				if (oc_inc >= eff_w) begin
					out_col_q <= '0;
					if (or_inc >= eff_h) begin
						out_row_q  <= '0;
						out_base_q <= out_base_q + eff_h[SW-1:0];
						in_ahead_q <= 1'b0;
					end else begin
						out_row_q <= or_inc[RW-1:0];
					end
				end else begin
					out_col_q <= oc_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_red_q   <= hsts.med[2*rmf_pkg::CH_W +: rmf_pkg::CH_W];
			out_green_q <= hsts.med[rmf_pkg::CH_W +: rmf_pkg::CH_W];
			out_blue_q  <= hsts.med[0 +: rmf_pkg::CH_W];
			out_last_q  <= {1'b0, out_row_q} == eff_h - (RW+1)'(1)
				&& {1'b0, out_col_q} == eff_w - (CW+1)'(1);
		end
	end

	assign pix_out.valid      = out_v_q;
	assign pix_out.red_out    = out_red_q;
	assign pix_out.green_out  = out_green_q;
	assign pix_out.blue_out   = out_blue_q;
	assign pix_out.frame_last = out_last_q;

	// column counters stay inside the image
	a_in_col: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, in_col_q} < eff_w && {1'b0, out_col_q} < eff_w)
		else $error("column counter outside image");

	// a scan is started only on an idle histogram with nothing in flight
	a_scan_go: assert property (@(posedge clk) disable iff (!arst_n)
		hcmd.scan_go |-> hsts.ready && !ls_rv_q)
		else $error("histogram scan started while busy");

	// scan completion only arrives while waiting for it
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		hsts.done |-> state_q == rmf_pkg::S_SCAN)
		else $error("unexpected scan completion");

	// every window holds at least the center pixel
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmf_pkg::S_FLUSH |-> n_q != '0)
		else $error("empty window");

endmodule

// ----- verif/rgb_median_filter_unit_tb.sv -----
module rgb_median_filter_unit_tb;

	// one predicted output pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} med_pix_t;

	typedef logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rmf_cfg_if cfg ();
	rmf_in_if  pix_in ();
	rmf_out_if pix_out ();

	rgb_median_filter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state: registers, counters, ring of rows
	logic [rmf_pkg::WREG_W-1:0]    width_reg;
	logic [rmf_pkg::HREG_W-1:0]    height_reg;
	logic [rmf_pkg::HALFREG_W-1:0] half_reg;
	logic [rmf_pkg::PIX_W-1:0]     row_ring [rmf_pkg::LS_DEPTH];
	int unsigned          in_r, in_c, out_r, out_c, in_base, out_base;
	bit                   in_next_frame;

	med_pix_t medians_q [$];
	int       errors;
	int       beats_in;
	int       beats_out;
	int       frames_seen;
	int       send_idle;
	int       recv_idle;

	task automatic report(input string what, input med_pix_t exp_p, input med_pix_t got_p);
		errors++;
		$display("mismatch %s: expected r%0d g%0d b%0d l%0d, got r%0d g%0d b%0d l%0d",
			what, exp_p.red, exp_p.green, exp_p.blue, exp_p.last,
			got_p.red, got_p.green, got_p.blue, got_p.last);
	endtask

	function automatic int unsigned eff_w();
		return (width_reg == 0) ? 1
			: (width_reg > rmf_pkg::MAX_WIDTH ? rmf_pkg::MAX_WIDTH : width_reg);
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg == 0) ? 1
			: (height_reg > rmf_pkg::MAX_HEIGHT ? rmf_pkg::MAX_HEIGHT : height_reg);
	endfunction

	function automatic void restart_framing();
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		in_base = 0; out_base = 0;
		in_next_frame = 0;
	endfunction

	// rank k of one channel among n gathered pixels
	function automatic logic [7:0] channel_rank(input logic [rmf_pkg::PIX_W-1:0] vals [],
			input int n, input int sh, input int k);
		int hist [256];
		int acc;
		for (int i = 0; i < 256; i++) hist[i] = 0;
		for (int i = 0; i < n; i++) hist[(vals[i] >> sh) & 8'hff]++;
		acc = 0;
		for (int i = 0; i < 256; i++) begin
			acc += hist[i];
			if (acc > k) return i[7:0];
		end
		return 8'hff;
	endfunction

	// advance the model by one accepted beat; queue the median it makes
	function automatic void median_step(input logic cmd, input logic [rmf_pkg::PIX_W-1:0] pix);
		int unsigned w, hgt, hw, lr, lc, slot;
		int r, c, n;
		bit rdy;
		logic [rmf_pkg::PIX_W-1:0] win [];
		med_pix_t m;
		w = eff_w(); hgt = eff_h(); hw = half_reg;
		if (cmd == rmf_pkg::CMD_PIXEL) begin
			row_ring[((in_base + in_r) % rmf_pkg::LS_ROWS) * rmf_pkg::MAX_WIDTH + in_c] = pix;
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r++;
				if (in_r >= hgt) begin
					in_r = 0;
					in_base = (in_base + hgt) % rmf_pkg::LS_ROWS;
					in_next_frame = 1;
				end
			end
		end
		if (in_next_frame) rdy = 1;
		else begin
			lr = out_r + hw; lc = out_c + hw;
			if (lr > hgt - 1) lr = hgt - 1;
			if (lc > w - 1) lc = w - 1;
			rdy = (in_r > lr) || (in_r == lr && in_c > lc);
		end
		if (!rdy) return;
		win = new[rmf_pkg::SIDE_MAX * rmf_pkg::SIDE_MAX];
		n = 0;
		for (int dr = -int'(hw); dr <= int'(hw); dr++) begin
			r = int'(out_r) + dr;
			if (r < 0 || r >= int'(hgt)) continue;
			slot = (out_base + r) % rmf_pkg::LS_ROWS;
			for (int dc = -int'(hw); dc <= int'(hw); dc++) begin
				c = int'(out_c) + dc;
				if (c < 0 || c >= int'(w)) continue;
				win[n++] = row_ring[slot * rmf_pkg::MAX_WIDTH + c];
			end
		end
		m.red   = channel_rank(win, n, 16, n / 2);
		m.green = channel_rank(win, n, 8, n / 2);
		m.blue  = channel_rank(win, n, 0, n / 2);
		m.last  = (out_r == hgt - 1 && out_c == w - 1);
		medians_q.push_back(m);
		out_c++;
		if (out_c >= w) begin
			out_c = 0;
			out_r++;
			if (out_r >= hgt) begin
				out_r = 0;
				out_base = (out_base + hgt) % rmf_pkg::LS_ROWS;
				in_next_frame = 0;
			end
		end
	endfunction

	// one input beat, with random idle cycles ahead of it
	task automatic send_pixel(input logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.cmd      <= cmd;
		pix_in.red_in   <= r;
		pix_in.green_in <= g;
		pix_in.blue_in  <= b;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		median_step(cmd, {r, g, b});
		beats_in++;
	endtask

	task automatic send_random_pixel();
		send_pixel(rmf_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// wait for all medians, then the block's worst-case busy time
	task automatic wait_idle();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (medians_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rmf_pkg::CFG_IDX_W-1:0] idx, input cfg_data_t val);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.addr  <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			rmf_pkg::CFG_WIDTH:  width_reg  = val[rmf_pkg::WREG_W-1:0];
			rmf_pkg::CFG_HEIGHT: height_reg = val[rmf_pkg::HREG_W-1:0];
			rmf_pkg::CFG_HALF:   half_reg   = val[rmf_pkg::HALFREG_W-1:0];
			default: ;
		endcase
		restart_framing();
	endtask

	task automatic set_geometry(input int w, input int hgt, input int hw);
		write_reg(rmf_pkg::CFG_WIDTH, cfg_data_t'(w));
		write_reg(rmf_pkg::CFG_HEIGHT, cfg_data_t'(hgt));
		write_reg(rmf_pkg::CFG_HALF, cfg_data_t'(hw));
	endtask

	// drain beats until the finished frame's tail is out
	task automatic flush_tail();
		while (in_next_frame)
			send_pixel(rmf_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// small frames with channel extremes, even window counts, clipped corners
	task automatic test_small_frames();
		logic [7:0] ext [4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
		set_geometry(3, 3, 1);
		for (int i = 0; i < 9; i++)
			send_pixel(rmf_pkg::CMD_PIXEL, ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4]);
		flush_tail();
		set_geometry(4, 2, 1);
		for (int i = 0; i < 8; i++)
			send_pixel(rmf_pkg::CMD_PIXEL, 8'(i * 37), 8'(255 - i * 30), i[0] ? 8'hff : 8'h00);
		send_pixel(rmf_pkg::CMD_DRAIN, 8'hff, 8'hff, 8'hff);
		flush_tail();
	endtask

	// clamped registers: zero width/height, oversized width/height, widest window
	task automatic test_register_clamps();
		set_geometry(0, 0, rmf_pkg::MAX_HALF);
		for (int i = 0; i < 3; i++) send_random_pixel();  // 1x1 frames back to back
		flush_tail();
		set_geometry(12'hfff, 1, 0);
		for (int i = 0; i < 12; i++) send_random_pixel();
		set_geometry(1, 13'h1fff, rmf_pkg::MAX_HALF);
		for (int i = 0; i < 14; i++) send_random_pixel();  // tail stays pending, dropped by write
		send_pixel(rmf_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
	endtask

	// random geometry; mostly whole frames, some cut short, drains sprinkled in
	task automatic test_random_frames(input int target);
		int w, hgt, frames, cut;
		while (beats_in < target) begin
			w = ($urandom_range(19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
			hgt = $urandom_range(1, 8);
			set_geometry(w, hgt, ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3));
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				for (int p = 0; p < w * hgt && beats_in < target; p++) begin
					if ($urandom_range(9) == 0)
						send_pixel(rmf_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
					send_random_pixel();
				end
				frames_seen++;
			end
			if ($urandom_range(4) == 0) begin
				// broken frame, abandoned by the next register write
				cut = $urandom_range(1, w * hgt);
				for (int p = 0; p < cut; p++) send_random_pixel();
			end else flush_tail();
		end
	endtask

	// compare every output beat with the oldest predicted median
	always @(posedge clk) begin
		med_pix_t got_p;
		med_pix_t exp_p;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			got_p = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.frame_last};
			beats_out++;
			if (medians_q.size() == 0) report("unexpected beat", '0, got_p);
			else begin
				exp_p = medians_q.pop_front();
				if (got_p.red !== exp_p.red) report("red", exp_p, got_p);
				if (got_p.green !== exp_p.green) report("green", exp_p, got_p);
				if (got_p.blue !== exp_p.blue) report("blue", exp_p, got_p);
				if (got_p.last !== exp_p.last) report("frame_last", exp_p, got_p);
			end
		end
		pix_out.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		pix_in.valid = 1'b0; pix_in.cmd = rmf_pkg::CMD_PIXEL;
		pix_in.red_in = '0; pix_in.green_in = '0; pix_in.blue_in = '0;
		pix_out.ready = 1'b0;
		cfg.valid = 1'b0; cfg.addr = rmf_pkg::CFG_WIDTH; cfg.data = '0;
		errors = 0; beats_in = 0; beats_out = 0; frames_seen = 0;
		send_idle = 35; recv_idle = 56;
		width_reg = rmf_pkg::WIDTH_RST; height_reg = rmf_pkg::HEIGHT_RST;
		half_reg = rmf_pkg::HALF_RST;
		restart_framing();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_small_frames();
		test_register_clamps();
		test_random_frames(420);
		send_idle = 56; recv_idle = 35;
		test_random_frames(800);
		send_idle = 0; recv_idle = 0;
		test_random_frames(1150);
		wait_idle();
		$display("covered %0d input beats, %0d output beats, %0d random frames",
			beats_in, beats_out, frames_seen);
		$display("geometry from 1x1 up to clamped extremes, windows up to 15x15, three idle mixes");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
src/rmf_pkg.sv
src/rmf_if.sv
src/rmf_ram.sv
src/rmf_hist.sv
src/rgb_median_filter_unit.sv
verif/rgb_median_filter_unit_tb.sv
